// ===== design/json_string_escaper_macros.svh =====
// Assertion macros shared by the checker files of the JSON string escaper.
// No dependencies; include with the bare file name.
`ifndef JSON_STRING_ESCAPER_MACROS_SVH
`define JSON_STRING_ESCAPER_MACROS_SVH

// Same-cycle implication, off while reset is asserted
`define JSE_ASSERT_NOW(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("jse assertion failed");

// Next-cycle implication, off while reset is asserted
`define JSE_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("jse assertion failed");

// Next-cycle implication that also watches reset itself
`define JSE_ASSERT_NEXT_ALWAYS(label, clk, ante, cons) \
    label: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error("jse assertion failed");

`endif

// ===== design/jse_pkg.sv =====
// Types, character constants and helpers for the JSON string escaper.
// No dependencies; imported by every module of the block.
package jse_pkg;

    // Work item kinds passed from the front to the back end
    typedef enum logic [1:0] {
        K_PLAIN   = 2'd0,  // byte passes through
        K_PAIR    = 2'd1,  // backslash plus one letter
        K_UNICODE = 2'd2,  // \u00xx
        K_CLOSE   = 2'd3   // closing quote
    } kind_t;

    // One queued work item
    typedef struct packed {
        kind_t      kind;
        logic       pre;   // emit opening quote first
        logic [2:0] len;   // total output bytes, 1..7
        logic [7:0] data;  // raw byte, or escape letter for K_PAIR
    } desc_t;

    // Input op codes
    localparam logic OP_BYTE = 1'b0;
    localparam logic OP_END  = 1'b1;

    // Characters
    localparam logic [7:0] CH_NUL    = 8'h00;
    localparam logic [7:0] CH_BS     = 8'h08;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_FF     = 8'h0C;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_LOW_A  = 8'h61;
    localparam logic [7:0] CH_LOW_B  = 8'h62;
    localparam logic [7:0] CH_LOW_F  = 8'h66;
    localparam logic [7:0] CH_LOW_N  = 8'h6E;
    localparam logic [7:0] CH_LOW_R  = 8'h72;
    localparam logic [7:0] CH_LOW_T  = 8'h74;
    localparam logic [7:0] CH_LOW_U  = 8'h75;
    localparam logic [7:0] CTRL_LIMIT = 8'h20;

    // Output lengths without the opening quote
    localparam logic [2:0] LEN_ONE     = 3'd1;
    localparam logic [2:0] LEN_PAIR    = 3'd2;
    localparam logic [2:0] LEN_UNICODE = 3'd6;

    // Lower-case hex digit for one nibble
    function automatic logic [7:0] hex_char(input logic [3:0] nib);
        logic [7:0] r;
        if (nib < 4'd10) begin
            r = CH_ZERO + {4'd0, nib};
        end else begin
            r = CH_LOW_A + {4'd0, nib - 4'd10};
        end
        return r;
    endfunction

endpackage

// ===== design/jse_front.sv =====
// Front end: accepts input transactions, tracks quote state, classifies bytes.
// Depends on jse_pkg; feeds jse_fifo.
module jse_front
    import jse_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       in_fire,   // input transaction accepted
    input  logic       in_op,
    input  logic [7:0] in_byte,
    output logic       push,
    output desc_t      push_desc
);

    logic quote_opened_reg, quote_opened_next;
    logic content_stopped_reg, content_stopped_next;

    // Classification and state update
    always_comb begin
        quote_opened_next    = quote_opened_reg;
        content_stopped_next = content_stopped_reg;
        push                 = 1'b0;
        push_desc.kind       = K_PLAIN;
        push_desc.pre        = !quote_opened_reg;
        push_desc.data       = in_byte;
        push_desc.len        = LEN_ONE;
        if (in_fire) begin
            if (in_op == OP_END) begin
                push                 = 1'b1;
                push_desc.kind       = K_CLOSE;
                quote_opened_next    = 1'b0;
                content_stopped_next = 1'b0;
            end else if (!content_stopped_reg) begin
                if (in_byte == CH_NUL) begin
                    content_stopped_next = 1'b1;
                end else begin
                    push              = 1'b1;
                    quote_opened_next = 1'b1;
                    case (in_byte)
                        CH_QUOTE, CH_BSLASH: begin
                            push_desc.kind = K_PAIR;
                            push_desc.len  = LEN_PAIR;
                        end
                        CH_BS: begin
                            push_desc.kind = K_PAIR;
                            push_desc.len  = LEN_PAIR;
                            push_desc.data = CH_LOW_B;
                        end
                        CH_FF: begin
                            push_desc.kind = K_PAIR;
                            push_desc.len  = LEN_PAIR;
                            push_desc.data = CH_LOW_F;
                        end
                        CH_LF: begin
                            push_desc.kind = K_PAIR;
                            push_desc.len  = LEN_PAIR;
                            push_desc.data = CH_LOW_N;
                        end
                        CH_CR: begin
                            push_desc.kind = K_PAIR;
                            push_desc.len  = LEN_PAIR;
                            push_desc.data = CH_LOW_R;
                        end
                        CH_TAB: begin
                            push_desc.kind = K_PAIR;
                            push_desc.len  = LEN_PAIR;
                            push_desc.data = CH_LOW_T;
                        end
                        default: begin
                            if (in_byte < CTRL_LIMIT) begin
                                push_desc.kind = K_UNICODE;
                                push_desc.len  = LEN_UNICODE;
                            end
                        end
                    endcase
                end
            end
        end
        // opening quote adds one byte
        push_desc.len = push_desc.len + {2'd0, push_desc.pre};
    end

    // State registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            quote_opened_reg    <= 1'b0;
            content_stopped_reg <= 1'b0;
        end else begin
            quote_opened_reg    <= quote_opened_next;
            content_stopped_reg <= content_stopped_next;
        end
    end

endmodule

// ===== design/jse_fifo.sv =====
// Short register queue of work items between front and back end.
// Depends on jse_pkg.
module jse_fifo
    import jse_pkg::*;
#(
    parameter int DEPTH = 4
) (
    input  logic  aclk,
    input  logic  aresetn,
    input  logic  push,
    input  desc_t push_desc,
    input  logic  pop,
    output desc_t head,
    output logic  not_empty,
    output logic  full
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

    desc_t         mem_reg [DEPTH];
    logic [PW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0] count_reg, count_next;

    assign head      = mem_reg[rd_ptr_reg];
    assign not_empty = (count_reg != '0);
    assign full      = (count_reg == FULL_CNT);

    // Pointer and count update
    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Storage, no reset
    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= push_desc;
        end
    end

endmodule

// ===== design/jse_back.sv =====
// Back end: expands queued work items into output bytes, one per ready cycle.
// Depends on jse_pkg; reads the head of jse_fifo, drives the output register.
module jse_back
    import jse_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  desc_t      head,
    input  logic       head_valid,
    output logic       pop,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [7:0] out_byte,
    output logic       out_last,
    output logic       out_done
);

    logic [2:0] idx_reg, idx_next;
    logic       valid_reg, valid_next;
    logic [7:0] byte_reg, byte_next;
    logic       last_reg, last_next;
    logic       done_reg, done_next;
    logic       load;
    logic [2:0] pos;   // position after the opening quote
    logic       at_end;

    assign load   = !valid_reg || out_ready;
    assign pos    = idx_reg - {2'd0, head.pre};
    assign at_end = (idx_reg == head.len - 3'd1);
    assign pop    = load && head_valid && at_end;

    // Byte selection for the current position
    always_comb begin
        byte_next = CH_QUOTE;
        done_next = 1'b0;
        if (head.pre && idx_reg == 3'd0) begin
            byte_next = CH_QUOTE;
        end else begin
            case (head.kind)
                K_PLAIN: byte_next = head.data;
                K_PAIR:  byte_next = (pos == 3'd0) ? CH_BSLASH : head.data;
                K_UNICODE: begin
                    case (pos)
                        3'd0:    byte_next = CH_BSLASH;
                        3'd1:    byte_next = CH_LOW_U;
                        3'd2:    byte_next = CH_ZERO;
                        3'd3:    byte_next = CH_ZERO;
                        3'd4:    byte_next = hex_char(head.data[7:4]);
                        3'd5:    byte_next = hex_char(head.data[3:0]);
                        default: byte_next = CH_ZERO;
                    endcase
                end
                K_CLOSE: begin
                    byte_next = CH_QUOTE;
                    done_next = 1'b1;
                end
                default: byte_next = head.data;
            endcase
        end
        last_next = at_end;
    end

    // Output register and position counter
    always_comb begin
        valid_next = valid_reg;
        idx_next   = idx_reg;
        if (load) begin
            valid_next = head_valid;
            if (head_valid) begin
                idx_next = at_end ? 3'd0 : idx_reg + 3'd1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
            idx_reg   <= 3'd0;
        end else begin
            valid_reg <= valid_next;
            idx_reg   <= idx_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load && head_valid) begin
            byte_reg <= byte_next;
            last_reg <= last_next;
            done_reg <= done_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_byte  = byte_reg;
    assign out_last  = last_reg;
    assign out_done  = done_reg;

endmodule

// ===== design/json_string_escaper.sv =====
// JSON string escaper, top level: front end, work queue, back end.
// Depends on jse_pkg, jse_front, jse_fifo, jse_back.
//
// Usage:
//   s_ side: one transaction per raw string byte (s_tuser = 0, byte in
//   s_tdata), then one end transaction (s_tuser = 1, s_tdata ignored).
//   m_ side: one transaction per byte of quoted JSON text. m_tlast marks the
//   final byte caused by an input transaction, m_tuser the closing quote.
//   A zero byte ends the content; later bytes up to the end are dropped.
//   An accepted transaction is first written into the work queue; its first
//   output byte then goes from the queue head into the output register.
//   Throughput: the input side takes one transaction per cycle while the
//   FIFO_DEPTH-entry work queue has room; the back end emits one byte per
//   ready cycle; an item gives 1 to 7 bytes (escapes 2, \u00xx 6, plus one
//   for the opening quote), and the output port sets the sustained rate.
//   Reset (aresetn low, synchronous) empties the queue and output register
//   and clears the quote state. When m_tready is low the output register
//   holds and the queue fills; s_tready drops only when the queue is full.
module json_string_escaper
    import jse_pkg::*;
#(
    parameter int FIFO_DEPTH = 4
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // [7:0] in_byte
    input  logic [0:0] s_tuser,   // [0] op
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,   // [7:0] out_byte
    output logic       m_tlast,
    output logic [0:0] m_tuser    // [0] string_done
);

    logic  in_fire;
    logic  push, pop, not_empty, full;
    desc_t push_desc, head;

    assign s_tready = !full;
    assign in_fire  = s_tvalid && s_tready;

    jse_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_fire   (in_fire),
        .in_op     (s_tuser[0]),
        .in_byte   (s_tdata),
        .push      (push),
        .push_desc (push_desc)
    );

    jse_fifo #(
        .DEPTH (FIFO_DEPTH)
    ) u_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_desc (push_desc),
        .pop       (pop),
        .head      (head),
        .not_empty (not_empty),
        .full      (full)
    );

    jse_back u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .head       (head),
        .head_valid (not_empty),
        .pop        (pop),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .out_byte   (m_tdata),
        .out_last   (m_tlast),
        .out_done   (m_tuser[0])
    );

endmodule

// ===== design/jse_checker.sv =====
// Port-level checker for the JSON string escaper, bound to the top level.
// Depends on jse_pkg and json_string_escaper_macros.svh.
`include "json_string_escaper_macros.svh"

module jse_checker
    import jse_pkg::*;
(
    input logic       aclk,
    input logic       aresetn,
    input logic       s_tready,
    input logic       m_tvalid,
    input logic       m_tready,
    input logic [7:0] m_tdata,
    input logic       m_tlast,
    input logic [0:0] m_tuser
);

    // Closing quote always ends the output of its transaction
    `JSE_ASSERT_NOW(a_done_is_last, aclk, aresetn, m_tvalid && m_tuser[0], m_tlast)

    // Closing quote carries the quote character
    `JSE_ASSERT_NOW(a_done_is_quote, aclk, aresetn, m_tvalid && m_tuser[0], m_tdata == CH_QUOTE)

    // Stalled output holds its byte
    `JSE_ASSERT_NEXT(a_stall_hold, aclk, aresetn, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tlast))

    // Reset clears the output register
    `JSE_ASSERT_NEXT_ALWAYS(a_reset_clear, aclk, !aresetn, !m_tvalid)

    // Reset empties the queue, so the input side is ready right after
    `JSE_ASSERT_NEXT_ALWAYS(a_reset_ready, aclk, !aresetn, s_tready)

endmodule

bind json_string_escaper jse_checker u_jse_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .m_tuser  (m_tuser)
);
